>>> rtl/tcps_pkg.sv
package tcps_pkg;

    // default configuration
    localparam int TABLE_DEPTH_DEF    = 256;
    localparam int PROB_FRAC_BITS_DEF = 31;

    // field widths fixed by the request format
    localparam int ENTRIES_W = 9;
    localparam int CHAR_W    = 8;
    localparam int CTXLEN_W  = 2;
    localparam int PROB_W    = 32;
    localparam int SLOT_W    = 8;

    // request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    // configuration register indexes (by word)
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    // context lengths
    localparam logic [CTXLEN_W-1:0] CTX_NONE = 2'd0;
    localparam logic [CTXLEN_W-1:0] CTX_TWO  = 2'd2;

    // one stored table entry
    typedef struct packed {
        logic [CHAR_W-1:0]   letter;
        logic [CTXLEN_W-1:0] ctx_len;
        logic [CHAR_W-1:0]   older;
        logic [CHAR_W-1:0]   newer;
        logic [PROB_W-1:0]   prob;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic search;
        logic mult;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic search_hit;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/tcps_ram.sv
module tcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tcps_ctrl.sv
module tcps_ctrl
    import tcps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cmd,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MULT   = 2'd2;
    localparam logic [1:0] ST_WRITE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_SCORE) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SEARCH;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    n_state = i_sts.search_hit ? ST_MULT : ST_WRITE;
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

>>> rtl/tcps_dp.sv
module tcps_dp
    import tcps_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [ENTRIES_W-1:0] i_entries,
    input  logic [SLOT_W-1:0]    i_entry_index,
    input  logic [CHAR_W-1:0]    i_entry_letter,
    input  logic [CTXLEN_W-1:0]  i_entry_context_length,
    input  logic [CHAR_W-1:0]    i_entry_context_older,
    input  logic [CHAR_W-1:0]    i_entry_context_newer,
    input  logic [PROB_W-1:0]    i_entry_probability,
    input  logic [CHAR_W-1:0]    i_symbol,
    input  logic                 i_word_start,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [PROB_W-1:0]    o_used_probability,
    output logic [PROB_W-1:0]    o_running_product,
    output logic                 o_entry_missing,
    output logic [SLOT_W-1:0]    o_matched_index
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;
    localparam int PROD_W = 2 * PROB_W;
    localparam logic [PROD_W-1:0] PROB_ONE = PROD_W'(1) << PROB_FRAC_BITS;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [LIM_W-1:0] t_lim;

    localparam t_lim DEPTH_LIM = t_lim'(TABLE_DEPTH);

    // scoring state
    logic [CHAR_W-1:0]   r_sym;
    logic [CTXLEN_W-1:0] r_ctx_len;
    logic [2*CHAR_W-1:0] r_ctx_chars;
    logic [PROB_W-1:0]   r_product;

    // search state
    t_lim                r_limit;
    t_lim                r_addr;
    logic                r_pend;
    t_idx                r_cmp_idx;
    logic                r_found;
    t_idx                r_hit_idx;
    logic [PROB_W-1:0]   r_prob;
    logic [PROD_W-1:0]   r_prod;

    // result register
    logic                r_out_valid;
    logic [PROB_W-1:0]   r_used;
    logic [PROB_W-1:0]   r_res_product;
    logic                r_missing;
    logic [SLOT_W-1:0]   r_matched;

    t_entry              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic                rd_en;
    logic                hit_now;
    logic                in_range;
    t_lim                n_limit;
    logic [PROD_W-1:0]   shifted;
    logic [PROB_W-1:0]   n_product;
    t_entry              wr_entry;

    // table store
    assign wr_en = i_cmd.load && (32'(i_entry_index) < TABLE_DEPTH);
    assign wr_entry = '{
        letter:  i_entry_letter,
        ctx_len: i_entry_context_length,
        older:   i_entry_context_older,
        newer:   i_entry_context_newer,
        prob:    i_entry_probability
    };

    tcps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (t_idx'(i_entry_index)),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    // compare the entry read last cycle against symbol and context
    always_comb begin
        hit_now = r_pend
               && (rd_entry.letter == r_sym)
               && (rd_entry.ctx_len == r_ctx_len)
               && ((r_ctx_len == CTX_NONE) || (rd_entry.newer == r_ctx_chars[CHAR_W-1:0]))
               && ((r_ctx_len != CTX_TWO)
                   || (rd_entry.older == r_ctx_chars[2*CHAR_W-1:CHAR_W]));
    end

    assign in_range = (r_addr < r_limit);
    assign rd_en    = i_cmd.search && in_range && !hit_now;

    assign o_sts.search_hit  = hit_now;
    assign o_sts.search_done = hit_now || (!r_pend && !in_range);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    // clamp register value to the table depth
    always_comb begin
        n_limit = t_lim'(i_entries);
        if (n_limit > DEPTH_LIM) begin
            n_limit = DEPTH_LIM;
        end
    end

    // truncate and saturate the product, or zero it on a miss
    always_comb begin
        shifted = r_prod >> PROB_FRAC_BITS;
        if (!r_found) begin
            n_product = '0;
        end else if (shifted > PROB_ONE) begin
            n_product = PROB_W'(PROB_ONE);
        end else begin
            n_product = shifted[PROB_W-1:0];
        end
    end

    // search walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_pend <= 1'b0;
        end else if (i_cmd.search) begin
            r_pend <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sym   <= i_symbol;
            r_limit <= n_limit;
            r_addr  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.search) begin
            if (rd_en) begin
                r_addr    <= r_addr + t_lim'(1);
                r_cmp_idx <= r_addr[IDX_W-1:0];
            end
            if (hit_now) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_prob    <= rd_entry.prob;
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(r_product) * PROD_W'(r_prob);
        end
    end

    // context and running product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_len   <= CTX_NONE;
            r_ctx_chars <= '0;
            r_product   <= PROB_W'(PROB_ONE);
        end else if (i_cmd.start && i_word_start) begin
            r_ctx_len   <= CTX_NONE;
            r_ctx_chars <= '0;
            r_product   <= PROB_W'(PROB_ONE);
        end else if (i_cmd.finish) begin
            r_ctx_chars <= {r_ctx_chars[CHAR_W-1:0], r_sym};
            if (r_ctx_len != CTX_TWO) begin
                r_ctx_len <= r_ctx_len + CTXLEN_W'(1);
            end
            r_product <= n_product;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_used        <= r_found ? r_prob : '0;
            r_res_product <= n_product;
            r_missing     <= !r_found;
            r_matched     <= r_found ? SLOT_W'(r_hit_idx) : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_used_probability = r_used;
    assign o_running_product  = r_res_product;
    assign o_entry_missing    = r_missing;
    assign o_matched_index    = r_matched;

endmodule

>>> rtl/trigram_char_prob_scorer.sv
// channel   | handshake                        | payload
// ----------+----------------------------------+-----------------------------------------
// request   | i_in_valid / o_in_stall          | i_cmd, i_entry_*, i_symbol, i_word_start
// result    | o_out_valid / i_out_stall        | o_used_probability, o_running_product,
//           |                                  | o_entry_missing, o_matched_index
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// a load request is taken while idle and gives no result
// a score request reads slots up to the first match (all covered slots on a miss);
//   the table RAM is read one slot per cycle
// synchronous active-low reset clears context, product and handshake state; table
//   contents stay undefined until loaded
// a finished result waits in the output register while the next request is taken;
//   a score request stalls in its write state while that register is full and stalled
module trigram_char_prob_scorer
    import tcps_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [SLOT_W-1:0]   i_entry_index,
    input  logic [CHAR_W-1:0]   i_entry_letter,
    input  logic [CTXLEN_W-1:0] i_entry_context_length,
    input  logic [CHAR_W-1:0]   i_entry_context_older,
    input  logic [CHAR_W-1:0]   i_entry_context_newer,
    input  logic [PROB_W-1:0]   i_entry_probability,
    input  logic [CHAR_W-1:0]   i_symbol,
    input  logic                i_word_start,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PROB_W-1:0]   o_used_probability,
    output logic [PROB_W-1:0]   o_running_product,
    output logic                o_entry_missing,
    output logic [SLOT_W-1:0]   o_matched_index,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [ENTRIES_W-1:0] r_entries;
    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_ENTRIES_IN_USE)) begin
            r_entries <= pwdata[ENTRIES_W-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ENTRIES_IN_USE) begin
            prdata = 32'(r_entries);
        end
    end

    tcps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tcps_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (dp_cmd),
        .o_sts                  (dp_sts),
        .i_entries              (r_entries),
        .i_entry_index          (i_entry_index),
        .i_entry_letter         (i_entry_letter),
        .i_entry_context_length (i_entry_context_length),
        .i_entry_context_older  (i_entry_context_older),
        .i_entry_context_newer  (i_entry_context_newer),
        .i_entry_probability    (i_entry_probability),
        .i_symbol               (i_symbol),
        .i_word_start           (i_word_start),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_used_probability     (o_used_probability),
        .o_running_product      (o_running_product),
        .o_entry_missing        (o_entry_missing),
        .o_matched_index        (o_matched_index)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcps_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int IDLE_SETTLE  = 8;
    localparam int END_SETTLE   = 300;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int REG_SPARE    = 1;

    localparam logic [CTXLEN_W-1:0] CTX_ONE   = 2'd1;
    localparam logic [CTXLEN_W-1:0] CTX_THREE = 2'd3;
    localparam logic [63:0]         PROB_ONE  = 64'd1 << PROB_FRAC_BITS_DEF;
    localparam logic [PROB_W-1:0]   PROB_UNIT = PROB_W'(PROB_ONE);

    // one request as offered on the input channel
    typedef struct {
        logic                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [CHAR_W-1:0]   letter;
        logic [CTXLEN_W-1:0] ctx_len;
        logic [CHAR_W-1:0]   older;
        logic [CHAR_W-1:0]   newer;
        logic [PROB_W-1:0]   prob;
        logic [CHAR_W-1:0]   symbol;
        logic                word_start;
    } request_t;

    // one character score
    typedef struct {
        logic [PROB_W-1:0] used_prob;
        logic [PROB_W-1:0] product;
        logic              missing;
        logic [SLOT_W-1:0] slot;
    } score_t;

    logic                i_clk                  = 1'b0;
    logic                i_rst_n                = 1'b0;
    logic                i_in_valid             = 1'b0;
    logic                o_in_stall;
    logic                i_cmd                  = CMD_LOAD;
    logic [SLOT_W-1:0]   i_entry_index          = '0;
    logic [CHAR_W-1:0]   i_entry_letter         = '0;
    logic [CTXLEN_W-1:0] i_entry_context_length = '0;
    logic [CHAR_W-1:0]   i_entry_context_older  = '0;
    logic [CHAR_W-1:0]   i_entry_context_newer  = '0;
    logic [PROB_W-1:0]   i_entry_probability    = '0;
    logic [CHAR_W-1:0]   i_symbol               = '0;
    logic                i_word_start           = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall            = 1'b0;
    logic [PROB_W-1:0]   o_used_probability;
    logic [PROB_W-1:0]   o_running_product;
    logic                o_entry_missing;
    logic [SLOT_W-1:0]   o_matched_index;
    logic                psel                   = 1'b0;
    logic                penable                = 1'b0;
    logic                pwrite                 = 1'b0;
    logic [2:0]          paddr                  = '0;
    logic [31:0]         pwdata                 = '0;
    logic [31:0]         prdata;
    logic                pready;

    // language model mirror
    t_entry                lm_table [TABLE_DEPTH_DEF];
    logic [ENTRIES_W-1:0]  lm_entries = '0;
    logic [15:0]           lm_ctx     = '0;
    logic [CTXLEN_W-1:0]   lm_ctx_len = CTX_NONE;
    logic [PROB_W-1:0]     lm_product = PROB_UNIT;

    score_t                expected_scores [$];
    logic [CHAR_W-1:0]     alphabet [4];
    int unsigned           err_count   = 0;
    int unsigned           cycle_count = 0;
    bit                    idle_on     = 1'b1;
    int unsigned           hold_req    = 0;
    int unsigned           hold_left   = 0;
    int unsigned           stall_left  = 0;

    trigram_char_prob_scorer dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_cmd                  (i_cmd),
        .i_entry_index          (i_entry_index),
        .i_entry_letter         (i_entry_letter),
        .i_entry_context_length (i_entry_context_length),
        .i_entry_context_older  (i_entry_context_older),
        .i_entry_context_newer  (i_entry_context_newer),
        .i_entry_probability    (i_entry_probability),
        .i_symbol               (i_symbol),
        .i_word_start           (i_word_start),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_used_probability     (o_used_probability),
        .o_running_product      (o_running_product),
        .o_entry_missing        (o_entry_missing),
        .o_matched_index        (o_matched_index),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void note_error(string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            note_error($sformatf("%s expected %h got %h", what, want, got));
    endfunction

    // slots the search covers
    function automatic int entry_limit();
        return (lm_entries > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(lm_entries);
    endfunction

    // context part of a match, letter aside
    function automatic bit context_fits(t_entry e, logic [CTXLEN_W-1:0] len, logic [15:0] ctx);
        return e.ctx_len == len
            && (len < CTX_ONE || e.newer == ctx[7:0])
            && (len < CTX_TWO || e.older == ctx[15:8]);
    endfunction

    // first-match lookup, product update and context shift for one character
    function automatic score_t score_char(logic [CHAR_W-1:0] sym, logic ws);
        score_t     r;
        logic [63:0] prod;
        bit         found;
        r     = '{default: '0};
        found = 1'b0;
        if (ws) begin
            lm_ctx_len = CTX_NONE;
            lm_ctx     = '0;
            lm_product = PROB_UNIT;
        end
        for (int i = 0; i < entry_limit() && !found; i++) begin
            if (lm_table[i].letter == sym && context_fits(lm_table[i], lm_ctx_len, lm_ctx)) begin
                found       = 1'b1;
                r.slot      = SLOT_W'(i);
                r.used_prob = lm_table[i].prob;
            end
        end
        if (found) begin
            prod = (64'(lm_product) * 64'(r.used_prob)) >> PROB_FRAC_BITS_DEF;
            if (prod > PROB_ONE)
                prod = PROB_ONE;
            lm_product = PROB_W'(prod);
        end else begin
            lm_product = '0;
        end
        lm_ctx = {lm_ctx[7:0], sym};
        if (lm_ctx_len < CTX_TWO)
            lm_ctx_len++;
        r.missing = !found;
        r.product = lm_product;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        score_t want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_scores.size() == 0) begin
                note_error("score result with no request pending");
            end else begin
                want = expected_scores.pop_front();
                check_field("used_probability", want.used_prob, o_used_probability);
                check_field("running_product", want.product, o_running_product);
                check_field("entry_missing", 32'(want.missing), 32'(o_entry_missing));
                check_field("matched_index", 32'(want.slot), 32'(o_matched_index));
            end
        end
    end

    // result side stall: random bursts plus requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // offer one request and hold it until taken; valid stays up afterwards
    task automatic send_request(request_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_cmd                  <= r.cmd;
        i_entry_index          <= r.slot;
        i_entry_letter         <= r.letter;
        i_entry_context_length <= r.ctx_len;
        i_entry_context_older  <= r.older;
        i_entry_context_newer  <= r.newer;
        i_entry_probability    <= r.prob;
        i_symbol               <= r.symbol;
        i_word_start           <= r.word_start;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (r.cmd == CMD_LOAD)
            lm_table[r.slot] = '{letter: r.letter, ctx_len: r.ctx_len, older: r.older,
                                 newer: r.newer, prob: r.prob};
        else
            expected_scores.insert(expected_scores.size(),
                                   score_char(r.symbol, r.word_start));
    endtask

    // sender idle until all scores are back, then settle
    task automatic drain_results(int settle);
        i_in_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // register write followed by a read back of entries_in_use
    task automatic write_register(int idx, logic [31:0] value);
        logic [31:0] got;
        drain_results(IDLE_SETTLE);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_ENTRIES_IN_USE)
            lm_entries = value[ENTRIES_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= 3'(REG_ENTRIES_IN_USE * 4);
        @(posedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("entries_in_use read back", 32'(lm_entries), got);
    endtask

    // random fill so unused fields toggle too
    function automatic request_t random_request();
        request_t r;
        r.cmd        = CMD_SCORE;
        r.slot       = SLOT_W'($urandom_range(0, 255));
        r.letter     = CHAR_W'($urandom_range(0, 255));
        r.ctx_len    = CTXLEN_W'($urandom_range(0, 3));
        r.older      = CHAR_W'($urandom_range(0, 255));
        r.newer      = CHAR_W'($urandom_range(0, 255));
        r.prob       = $urandom();
        r.symbol     = CHAR_W'($urandom_range(0, 255));
        r.word_start = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic load_entry(logic [SLOT_W-1:0] slot, logic [CHAR_W-1:0] letter,
                              logic [CTXLEN_W-1:0] len, logic [CHAR_W-1:0] older,
                              logic [CHAR_W-1:0] newer, logic [PROB_W-1:0] prob);
        request_t r;
        r         = random_request();
        r.cmd     = CMD_LOAD;
        r.slot    = slot;
        r.letter  = letter;
        r.ctx_len = len;
        r.older   = older;
        r.newer   = newer;
        r.prob    = prob;
        send_request(r);
    endtask

    task automatic score_symbol(logic [CHAR_W-1:0] sym, logic ws);
        request_t r;
        r            = random_request();
        r.cmd        = CMD_SCORE;
        r.symbol     = sym;
        r.word_start = ws;
        send_request(r);
    endtask

    // mostly near one so products survive a few letters
    function automatic logic [PROB_W-1:0] random_prob();
        case ($urandom_range(0, 11))
            0:       return $urandom();
            1:       return PROB_UNIT;
            2:       return PROB_W'($urandom_range(0, 255));
            default: return PROB_W'($urandom_range(32'h5800_0000, 32'h8000_0000));
        endcase
    endfunction

    task automatic new_alphabet();
        for (int k = 0; k < 4; k++)
            alphabet[k] = CHAR_W'($urandom_range(0, 255));
    endtask

    function automatic logic [CHAR_W-1:0] pick_letter();
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic load_random_entry(logic [SLOT_W-1:0] slot);
        int unsigned         roll;
        logic [CTXLEN_W-1:0] len;
        roll = $urandom_range(0, 19);
        if (roll < 5)
            len = CTX_NONE;
        else if (roll < 12)
            len = CTX_ONE;
        else if (roll < 19)
            len = CTX_TWO;
        else
            len = CTX_THREE;
        load_entry(slot, pick_letter(), len, pick_letter(), pick_letter(), random_prob());
    endtask

    // letter that some covered entry predicts in the current context, usually
    function automatic logic [CHAR_W-1:0] next_symbol(logic ws);
        logic [CHAR_W-1:0]   hits [$];
        logic [CTXLEN_W-1:0] len;
        logic [15:0]         ctx;
        len = ws ? CTX_NONE : lm_ctx_len;
        ctx = ws ? 16'h0000 : lm_ctx;
        for (int i = 0; i < entry_limit(); i++)
            if (context_fits(lm_table[i], len, ctx))
                hits.insert(hits.size(), lm_table[i].letter);
        if (hits.size() == 0 || $urandom_range(0, 6) == 0)
            return pick_letter();
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // one word, with the odd table reload or stray character mixed in
    task automatic score_word(int len);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
                0:       load_random_entry(SLOT_W'($urandom_range(0, 255)));
                1:       score_symbol(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                default: ;
            endcase
            score_symbol(next_symbol(k == 0), k == 0);
        end
    endtask

    // nothing covered: every character misses, first one without a word start
    task automatic test_empty_table();
        score_symbol(8'h78, 1'b0);
        score_symbol(8'h79, 1'b1);
    endtask

    // hand-built table: saturation, first match, unmatched length three, zero and tiny probs
    task automatic test_directed_words();
        load_entry(8'd0, 8'h61, CTX_NONE,  8'h00, 8'h00, 32'hFFFF_FFFF);
        load_entry(8'd1, 8'h61, CTX_NONE,  8'h00, 8'h00, 32'h4000_0000);
        load_entry(8'd2, 8'h62, CTX_ONE,   8'h00, 8'h61, PROB_UNIT);
        load_entry(8'd3, 8'h63, CTX_TWO,   8'h61, 8'h62, 32'h6000_0001);
        load_entry(8'd4, 8'h63, CTX_THREE, 8'h61, 8'h62, PROB_UNIT);
        load_entry(8'd5, 8'h64, CTX_TWO,   8'h62, 8'h63, 32'h0000_0000);
        load_entry(8'd6, 8'hFF, CTX_ONE,   8'h00, 8'h00, 32'h0000_0001);
        load_entry(8'd7, 8'h00, CTX_NONE,  8'hFF, 8'hFF, 32'h7FFF_FFFF);
        write_register(REG_ENTRIES_IN_USE, 32'd8);
        score_symbol(8'h61, 1'b1);
        score_symbol(8'h62, 1'b0);
        score_symbol(8'h63, 1'b0);
        score_symbol(8'h64, 1'b0);
        score_symbol(8'h61, 1'b0);
        score_symbol(8'h63, 1'b1);
        score_symbol(8'h00, 1'b1);
        score_symbol(8'hFF, 1'b0);
        score_symbol(8'h61, 1'b1);
    endtask

    // spare index is ignored, extremes read back
    task automatic test_register_writes();
        write_register(REG_SPARE, 32'h0000_01FF);
        write_register(REG_ENTRIES_IN_USE, 32'h0000_01FF);
        write_register(REG_ENTRIES_IN_USE, 32'd0);
        write_register(REG_ENTRIES_IN_USE, 32'd8);
    endtask

    // small tables, mostly well-formed words
    task automatic test_random_words();
        int n;
        repeat (8) begin
            n = $urandom_range(4, 40);
            new_alphabet();
            for (int s = 0; s < n; s++)
                load_random_entry(SLOT_W'(s));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_ENTRIES_IN_USE, 32'($urandom_range(0, n)));
            else
                write_register(REG_ENTRIES_IN_USE, 32'(n));
            repeat (12) score_word($urandom_range(1, 6));
        end
    endtask

    // every slot loaded, search over all of them and past the register limit
    task automatic test_full_table();
        logic [CHAR_W-1:0] last_letter;
        new_alphabet();
        last_letter = ~alphabet[0];
        for (int s = 0; s < TABLE_DEPTH_DEF - 1; s++)
            load_random_entry(SLOT_W'(s));
        load_entry(8'hFF, last_letter, CTX_NONE, 8'h00, 8'hFF, random_prob());
        write_register(REG_ENTRIES_IN_USE, 32'(TABLE_DEPTH_DEF));
        repeat (4) score_word($urandom_range(1, 5));
        score_symbol(last_letter, 1'b1);
        write_register(REG_ENTRIES_IN_USE, 32'h0000_01FF);
        repeat (3) score_word($urandom_range(1, 5));
        score_symbol(last_letter, 1'b1);
    endtask

    // result side held off while requests keep coming, then a paused sender
    task automatic test_backpressure();
        write_register(REG_ENTRIES_IN_USE, 32'd24);
        hold_req = LONG_HOLD;
        repeat (3) score_word(6);
        drain_results(IDLE_SETTLE);
        score_symbol(next_symbol(1'b1), 1'b1);
        score_symbol(next_symbol(1'b0), 1'b0);
        // sender waits mid-word until every score is back
        drain_results(IDLE_SETTLE);
        score_symbol(next_symbol(1'b0), 1'b0);
        score_symbol(next_symbol(1'b0), 1'b0);
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_register(REG_ENTRIES_IN_USE, 32'($urandom_range(8, 64)));
        repeat (12) score_word($urandom_range(1, 6));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed_words();
        test_register_writes();
        test_random_words();
        test_full_table();
        test_backpressure();
        test_steady_stream();

        drain_results(END_SETTLE);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
